@@ rtl/fbcc_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the framed block CRC checker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package fbcc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 32768;

  // Register reset value: the block cap, clipped to the 16-bit register.
  localparam logic [15:0] MAX_LEN_RESET =
    (MAX_BLOCK_BYTES > 32'hFFFF) ? 16'hFFFF : 16'(MAX_BLOCK_BYTES);
  localparam logic [31:0] MAX_LEN_CAP = 32'(MAX_BLOCK_BYTES);

  localparam logic [31:0] TYPE_CRC   = 32'h0000_0005;
  localparam logic [31:0] TYPE_DATA  = 32'h0000_0006;
  localparam logic [31:0] TYPE_ERROR = 32'h0000_00FF;
  localparam logic [31:0] CRC_MSG_LEN = 32'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;

  // Command queue between parser and checker; depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CRC_MSG = 3'd1,
    ST_SERVER_ERR  = 3'd2,
    ST_BAD_TYPE    = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_MISMATCH    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CRC    = 2'd1,
    PH_DATA   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic {
    CMD_DATA = 1'b0,  // one payload byte of a data block
    CMD_EMIT = 1'b1   // finish a pair without further CRC bytes
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        first;     // first payload byte: restart CRC
    logic        last;      // last payload byte: report result
    logic [7:0]  data;
    status_t     status;
    logic [31:0] length;
    logic [31:0] expected;
  } cmd_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/fbcc_front.sv @@
// Stream parser: header assembly, message classification, command generation.
// Depends on fbcc_pkg.
`timescale 1ns / 1ps

module fbcc_front
  import fbcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  input  logic [7:0]  rx_byte,
  input  logic        q_full,
  output logic        in_stall,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [15:0] max_block_length;
  phase_t      phase, phase_next;
  logic        expecting_data, expecting_data_next;
  logic [2:0]  header_index, header_index_next;
  logic [31:0] message_type, message_type_next;
  logic [31:0] message_length, message_length_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  status_t     held_status, held_status_next;
  logic [31:0] crc_expected, crc_expected_next;
  logic        data_first, data_first_next;

  logic        accept;
  logic [31:0] len_shift;
  logic [31:0] limit;
  logic        fail;
  status_t     fail_st;
  logic        rem_last;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign len_shift = {message_length[23:0], rx_byte};
  assign limit = ({16'h0, max_block_length} < MAX_LEN_CAP) ?
                 {16'h0, max_block_length} : MAX_LEN_CAP;
  assign rem_last = (payload_remaining == 32'd1);

  // Header checks; only meaningful on the eighth header byte.
  always_comb begin
    fail    = 1'b0;
    fail_st = ST_OK;
    if (!expecting_data) begin
      if (!(message_type == TYPE_CRC && len_shift == CRC_MSG_LEN)) begin
        fail    = 1'b1;
        fail_st = ST_BAD_CRC_MSG;
      end
    end else if (len_shift > limit) begin
      fail    = 1'b1;
      fail_st = ST_TOO_LONG;
    end else if (message_type == TYPE_ERROR) begin
      fail    = 1'b1;
      fail_st = ST_SERVER_ERR;
    end else if (message_type != TYPE_DATA) begin
      fail    = 1'b1;
      fail_st = ST_BAD_TYPE;
    end
  end

  always_comb begin
    phase_next             = phase;
    expecting_data_next    = expecting_data;
    header_index_next      = header_index;
    message_type_next      = message_type;
    message_length_next    = message_length;
    payload_remaining_next = payload_remaining;
    held_status_next       = held_status;
    crc_expected_next      = crc_expected;
    data_first_next        = data_first;
    push                   = 1'b0;
    push_cmd.kind          = CMD_EMIT;
    push_cmd.first         = 1'b0;
    push_cmd.last          = 1'b0;
    push_cmd.data          = rx_byte;
    push_cmd.status        = ST_OK;
    push_cmd.length        = message_length;
    push_cmd.expected      = crc_expected;

    if (accept) begin
      unique case (phase)
        PH_CRC: begin
          crc_expected_next      = {crc_expected[23:0], rx_byte};
          payload_remaining_next = payload_remaining - 32'd1;
          if (rem_last) begin
            expecting_data_next = 1'b1;
            phase_next          = PH_HEADER;
            header_index_next   = '0;
          end
        end
        PH_DATA: begin
          push                   = 1'b1;
          push_cmd.kind          = CMD_DATA;
          push_cmd.first         = data_first;
          push_cmd.last          = rem_last;
          data_first_next        = 1'b0;
          payload_remaining_next = payload_remaining - 32'd1;
          if (rem_last) begin
            expecting_data_next = 1'b0;
            phase_next          = PH_HEADER;
            header_index_next   = '0;
          end
        end
        PH_SKIP: begin
          payload_remaining_next = payload_remaining - 32'd1;
          if (rem_last) begin
            push                = 1'b1;
            push_cmd.status     = held_status;
            expecting_data_next = 1'b0;
            phase_next          = PH_HEADER;
            header_index_next   = '0;
          end
        end
        PH_HEADER: begin
          if (header_index < 3'd4) begin
            message_type_next = {message_type[23:0], rx_byte};
          end else begin
            message_length_next = len_shift;
          end
          header_index_next = header_index + 3'd1;
          if (header_index == 3'd7) begin
            push_cmd.length = len_shift;
            if (fail) begin
              held_status_next = fail_st;
              if (len_shift == 32'd0) begin
                push                = 1'b1;
                push_cmd.status     = fail_st;
                expecting_data_next = 1'b0;
              end else begin
                payload_remaining_next = len_shift;
                phase_next             = PH_SKIP;
              end
            end else if (!expecting_data) begin
              payload_remaining_next = CRC_MSG_LEN;
              phase_next             = PH_CRC;
            end else if (len_shift == 32'd0) begin
              // empty block: CRC of nothing is checked right away
              push                = 1'b1;
              push_cmd.status     = ST_OK;
              expecting_data_next = 1'b0;
            end else begin
              payload_remaining_next = len_shift;
              data_first_next        = 1'b1;
              phase_next             = PH_DATA;
            end
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_length  <= MAX_LEN_RESET;
      phase             <= PH_HEADER;
      expecting_data    <= 1'b0;
      header_index      <= '0;
      message_type      <= '0;
      message_length    <= '0;
      payload_remaining <= '0;
      held_status       <= ST_OK;
      crc_expected      <= '0;
      data_first        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_block_length <= cfg_write_data;
      end
      phase             <= phase_next;
      expecting_data    <= expecting_data_next;
      header_index      <= header_index_next;
      message_type      <= message_type_next;
      message_length    <= message_length_next;
      payload_remaining <= payload_remaining_next;
      held_status       <= held_status_next;
      crc_expected      <= crc_expected_next;
      data_first        <= data_first_next;
    end
  end

endmodule

@@ rtl/fbcc_queue.sv @@
// Small command queue between the parser and the CRC/report stage.
// Depends on fbcc_pkg.
`timescale 1ns / 1ps

module fbcc_queue
  import fbcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output cmd_t q_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_cmd   = entries[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/fbcc_back.sv @@
// CRC-32 engine, final check, saturating counters and the result register.
// Depends on fbcc_pkg.
`timescale 1ns / 1ps

module fbcc_back
  import fbcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] block_length,
  output logic [31:0] carried_crc,
  output logic [31:0] computed_crc,
  output logic [31:0] good_block_count,
  output logic [31:0] good_byte_count,
  output logic [31:0] fault_count
);

  logic [31:0] crc_running;
  logic [31:0] crc_in;
  logic [31:0] crc_step;
  logic [31:0] comp;
  logic        produce;
  logic        check;
  status_t     st;
  logic [31:0] comp_out;
  logic [31:0] exp_out;
  logic [32:0] byte_sum;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    crc_in   = q_cmd.first ? CRC_INIT : crc_running;
    crc_step = crc_byte(crc_in, q_cmd.data);
    produce  = (q_cmd.kind == CMD_EMIT) || q_cmd.last;
    // a finished data block (possibly empty) gets compared
    check    = (q_cmd.kind == CMD_DATA) || (q_cmd.status == ST_OK);
    comp     = (q_cmd.kind == CMD_DATA) ? ~crc_step : ~CRC_INIT;
    if (check) begin
      st       = (comp == q_cmd.expected) ? ST_OK : ST_MISMATCH;
      comp_out = comp;
    end else begin
      st       = q_cmd.status;
      comp_out = '0;
    end
    exp_out  = (st == ST_BAD_CRC_MSG) ? 32'h0 : q_cmd.expected;
    byte_sum = {1'b0, good_byte_count} + {1'b0, q_cmd.length};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      crc_running      <= CRC_INIT;
      good_block_count <= '0;
      good_byte_count  <= '0;
      fault_count      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (q_cmd.kind == CMD_DATA) begin
          crc_running <= crc_step;
        end
        if (produce) begin
          out_valid <= 1'b1;
          if (st == ST_OK) begin
            if (good_block_count != SAT_MAX) begin
              good_block_count <= good_block_count + 32'd1;
            end
            good_byte_count <= byte_sum[32] ? SAT_MAX : byte_sum[31:0];
          end else if (fault_count != SAT_MAX) begin
            fault_count <= fault_count + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      status       <= 3'(st);
      block_length <= q_cmd.length;
      carried_crc  <= exp_out;
      computed_crc <= comp_out;
    end
  end

endmodule

@@ rtl/framed_block_crc_checker.sv @@
// Framed block CRC checker: parses type/length framed messages, checks CRC-32 of data blocks.
// Throughput: one rx_byte per cycle; in_stall rises only when the two-entry command
// queue is full, i.e. while out_stall holds a pending status.
// Path: the byte that completes the pair is queued, then the CRC check loads the output
// register; while out_stall holds a pending status, the queued command waits to be popped.
// Reset (rst, synchronous): parser back to header, counters cleared, limit to 32768.
`timescale 1ns / 1ps

module framed_block_crc_checker
  import fbcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] block_length,
  output logic [31:0] carried_crc,
  output logic [31:0] computed_crc,
  output logic [31:0] good_block_count,
  output logic [31:0] good_byte_count,
  output logic [31:0] fault_count
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  logic q_full;
  cmd_t q_cmd;

  fbcc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .rx_byte        (rx_byte),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  fbcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  fbcc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .block_length     (block_length),
    .carried_crc      (carried_crc),
    .computed_crc     (computed_crc),
    .good_block_count (good_block_count),
    .good_byte_count  (good_byte_count),
    .fault_count      (fault_count)
  );

endmodule

@@ test/testbench.sv @@
// Testbench for framed_block_crc_checker: drives framed byte streams, predicts every
// status item in a scoreboard class and compares them as they leave the block.
// Depends on rtl/fbcc_pkg.sv and rtl/framed_block_crc_checker.sv.
`timescale 1ns / 1ps

module testbench;
  import fbcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 240;
  localparam int unsigned RANDOM_BYTES_PER_PHASE = 80;

  typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] length;
    logic [31:0] exp_crc;
    logic [31:0] comp_crc;
    logic [31:0] blocks;
    logic [31:0] bytes_ok;
    logic [31:0] faults;
  } status_report_t;

  class frame_status_board;
    logic [15:0]    max_len;
    phase_t         phase;
    bit             expecting_data;
    logic [2:0]     hdr_index;
    logic [31:0]    frame_type;
    logic [31:0]    msg_len;
    logic [31:0]    remaining;
    status_t        held;
    logic [31:0]    crc_expected;
    logic [31:0]    crc_running;
    logic [31:0]    good_blocks;
    logic [31:0]    good_bytes;
    logic [31:0]    fault_pairs;
    status_report_t statuses_due[$];
    int unsigned    failures;

    function new();
      max_len = MAX_LEN_RESET;
      phase = PH_HEADER;
      expecting_data = 1'b0;
      hdr_index = '0;
      frame_type = '0;
      msg_len = '0;
      remaining = '0;
      held = ST_OK;
      crc_expected = '0;
      crc_running = CRC_INIT;
      good_blocks = '0;
      good_bytes = '0;
      fault_pairs = '0;
      failures = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      max_len = value;
    endfunction

    function int unsigned outstanding();
      return statuses_due.size();
    endfunction

    function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
        c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      return c;
    endfunction

    function void finish_pair(status_t code);
      status_report_t r;
      logic [32:0] sum;
      r.code = code;
      r.length = msg_len;
      r.exp_crc = crc_expected;
      r.comp_crc = '0;
      if (code == ST_OK || code == ST_MISMATCH) begin
        r.comp_crc = ~crc_running;
        r.code = (r.comp_crc == crc_expected) ? ST_OK : ST_MISMATCH;
      end
      if (r.code == ST_BAD_CRC_MSG)
        r.exp_crc = '0;
      if (r.code == ST_OK) begin
        sum = {1'b0, good_bytes} + {1'b0, msg_len};
        good_blocks = (good_blocks == SAT_MAX) ? good_blocks : good_blocks + 1;
        good_bytes = sum[32] ? SAT_MAX : sum[31:0];
      end else begin
        fault_pairs = (fault_pairs == SAT_MAX) ? fault_pairs : fault_pairs + 1;
      end
      r.blocks = good_blocks;
      r.bytes_ok = good_bytes;
      r.faults = fault_pairs;
      statuses_due.push_back(r);
      expecting_data = 1'b0;
      phase = PH_HEADER;
      hdr_index = '0;
      remaining = '0;
    endfunction

    // a faulty message still has its payload skipped before the status goes out
    function void skip_or_fail(status_t code);
      held = code;
      if (msg_len == 0) begin
        finish_pair(code);
      end else begin
        remaining = msg_len;
        phase = PH_SKIP;
      end
    endfunction

    function void header_done();
      logic [31:0] limit;
      limit = ({16'd0, max_len} < MAX_LEN_CAP) ? {16'd0, max_len} : MAX_LEN_CAP;
      hdr_index = '0;
      if (!expecting_data) begin
        if (frame_type == TYPE_CRC && msg_len == CRC_MSG_LEN) begin
          remaining = CRC_MSG_LEN;
          phase = PH_CRC;
        end else begin
          skip_or_fail(ST_BAD_CRC_MSG);
        end
      end else if (msg_len > limit) begin
        skip_or_fail(ST_TOO_LONG);
      end else if (frame_type == TYPE_ERROR) begin
        skip_or_fail(ST_SERVER_ERR);
      end else if (frame_type != TYPE_DATA) begin
        skip_or_fail(ST_BAD_TYPE);
      end else begin
        crc_running = CRC_INIT;
        if (msg_len == 0) begin
          finish_pair(ST_OK);
        end else begin
          remaining = msg_len;
          phase = PH_DATA;
        end
      end
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PH_CRC: begin
          crc_expected = {crc_expected[23:0], b};
          remaining--;
          if (remaining == 0) begin
            expecting_data = 1'b1;
            phase = PH_HEADER;
            hdr_index = '0;
          end
        end
        PH_DATA: begin
          crc_running = crc_step(crc_running, b);
          remaining--;
          if (remaining == 0)
            finish_pair(ST_OK);
        end
        PH_SKIP: begin
          remaining--;
          if (remaining == 0)
            finish_pair(held);
        end
        default: begin
          phase = PH_HEADER;
          if (hdr_index < 4)
            frame_type = {frame_type[23:0], b};
          else
            msg_len = {msg_len[23:0], b};
          if (hdr_index == 3'd7)
            header_done();
          else
            hdr_index++;
        end
      endcase
    endfunction

    function string describe(status_report_t r);
      return $sformatf({"status %0d length %0d carried_crc %h computed_crc %h",
                        " blocks %0d bytes %0d faults %0d"},
                       r.code, r.length, r.exp_crc, r.comp_crc, r.blocks, r.bytes_ok,
                       r.faults);
    endfunction

    function void compare_status(status_report_t got);
      status_report_t want;
      if (statuses_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected status item: %s", describe(got));
        return;
      end
      want = statuses_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("status item mismatch");
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [31:0] block_length;
  logic [31:0] carried_crc;
  logic [31:0] computed_crc;
  logic [31:0] good_block_count;
  logic [31:0] good_byte_count;
  logic [31:0] fault_count;

  frame_status_board board = new();

  logic [15:0] limit_now = MAX_LEN_RESET;
  int unsigned bytes_sent = 0;
  int unsigned calm_left = 0;
  bit          steady = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned cycle_count = 0;

  framed_block_crc_checker i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .block_length     (block_length),
    .carried_crc      (carried_crc),
    .computed_crc     (computed_crc),
    .good_block_count (good_block_count),
    .good_byte_count  (good_byte_count),
    .fault_count      (fault_count)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady || calm_left != 0) begin
      if (calm_left != 0)
        calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 62)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_byte(value);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] word);
    for (int i = 3; i >= 0; i--)
      send_byte(word[8*i +: 8]);
  endtask

  task automatic send_header(input logic [31:0] kind, input logic [31:0] len);
    send_word(kind);
    send_word(len);
  endtask

  task automatic send_filler(input int unsigned count);
    repeat (count) send_byte(8'($urandom));
  endtask

  task automatic send_crc_message(input logic [31:0] crc);
    send_header(TYPE_CRC, CRC_MSG_LEN);
    send_word(crc);
  endtask

  task automatic send_block_pair(input int unsigned len, input bit corrupt, input fill_t fill);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int unsigned i = 0; i < len; i++) begin
      b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
      body.push_back(b);
      crc = board.crc_step(crc, b);
    end
    crc = ~crc;
    if (corrupt)
      crc ^= 32'd1 << $urandom_range(0, 31);
    send_crc_message(crc);
    send_header(TYPE_DATA, len);
    foreach (body[i])
      send_byte(body[i]);
  endtask

  // valid CRC message, then a data position message that should fail
  task automatic send_faulty_data(input logic [31:0] kind, input int unsigned len);
    send_crc_message($urandom);
    send_header(kind, len);
    send_filler(len);
  endtask

  task automatic send_bad_crc_message(input logic [31:0] kind, input int unsigned len);
    send_header(kind, len);
    send_filler(len);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [15:0] value);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    board.set_limit(value);
    limit_now = value;
  endtask

  // receiver holds off while short pairs keep coming, so the block backs up
  task automatic press_output();
    hold_requests++;
    steady = 1'b1;
    repeat (16) send_block_pair(0, 1'b0, FILL_RANDOM);
    steady = 1'b0;
  endtask

  task automatic random_pair();
    int unsigned lim;
    int unsigned len;
    int unsigned r;
    logic [31:0] kind;
    lim = ({16'd0, limit_now} < MAX_LEN_CAP) ? limit_now : MAX_LEN_CAP;
    r = $urandom_range(0, 99);
    if (r < 10)
      len = 0;
    else if (r < 65)
      len = $urandom_range(1, 16);
    else if (r < 92)
      len = $urandom_range(17, 64);
    else
      len = $urandom_range(65, 200);
    if (len > lim)
      len = $urandom_range(0, lim);
    r = $urandom_range(0, 99);
    if (r < 52) begin
      send_block_pair(len, 1'b0, FILL_RANDOM);
    end else if (r < 62) begin
      send_block_pair(len, 1'b1, FILL_RANDOM);
    end else if (r < 70) begin
      send_faulty_data(TYPE_ERROR, len);
    end else if (r < 78) begin
      kind = $urandom;
      if (kind == TYPE_DATA || kind == TYPE_ERROR)
        kind = TYPE_CRC;
      send_faulty_data(kind, len);
    end else if (r < 86 && lim <= 400) begin
      case ($urandom_range(0, 2))
        0: kind = TYPE_DATA;
        1: kind = TYPE_ERROR;
        default: kind = $urandom;
      endcase
      send_faulty_data(kind, lim + $urandom_range(1, 6));
    end else if (r < 86) begin
      send_block_pair(len, 1'b0, FILL_RANDOM);
    end else if (r < 98) begin
      case ($urandom_range(0, 3))
        0: kind = TYPE_DATA;
        1: kind = TYPE_CRC;
        default: kind = $urandom;
      endcase
      len = $urandom_range(0, 9);
      if (kind == TYPE_CRC && len == CRC_MSG_LEN)
        len = 0;
      send_bad_crc_message(kind, len);
    end else begin
      wait_idle();
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned r;
    bit          run_stall;
    bit          next_stall;
    hold_left = 0;
    run_left = 0;
    run_stall = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.compare_status({status, block_length, carried_crc, computed_crc,
                              good_block_count, good_byte_count, fault_count});
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            run_stall = 1'b0;
            run_left = $urandom_range(1, 20);
          end else if (r < 80) begin
            run_stall = 1'b1;
            run_left = $urandom_range(1, 3);
          end else if (r < 93) begin
            run_stall = 1'b1;
            run_left = $urandom_range(4, 12);
          end else if (r < 97) begin
            run_stall = 1'b1;
            run_left = $urandom_range(20, 60);
          end else begin
            run_stall = 1'b0;
            run_left = $urandom_range(50, 200);
          end
        end
        run_left--;
        next_stall = run_stall;
      end
      out_stall <= next_stall;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] phase_limits [7];
    int unsigned mark;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    rx_byte        <= 8'h00;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 16'h0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, limit still at its reset value
    send_block_pair(0, 1'b0, FILL_RANDOM);     // empty block, CRC of nothing is zero
    send_block_pair(0, 1'b1, FILL_RANDOM);
    send_block_pair(1, 1'b0, FILL_ZERO);
    send_block_pair(4, 1'b0, FILL_ONES);
    send_block_pair(7, 1'b1, FILL_RANDOM);
    send_bad_crc_message(TYPE_DATA, CRC_MSG_LEN);
    send_bad_crc_message(TYPE_CRC, 3);
    send_bad_crc_message(TYPE_CRC, 0);         // fails on the last header byte
    send_bad_crc_message(32'hFFFF_FFFF, 8);
    send_faulty_data(TYPE_ERROR, 3);
    send_faulty_data(TYPE_ERROR, 0);
    send_faulty_data(TYPE_CRC, 2);
    send_faulty_data(32'hFFFF_FF06, 0);

    // register at its largest value, above the cap
    set_max_length(16'hFFFF);
    send_block_pair(40, 1'b0, FILL_RANDOM);

    set_max_length(16'd0);
    send_block_pair(0, 1'b0, FILL_RANDOM);
    send_faulty_data(TYPE_DATA, 1);
    send_faulty_data(TYPE_ERROR, 0);
    send_faulty_data(TYPE_ERROR, 1);           // length checked before type
    send_faulty_data(TYPE_CRC, 0);

    set_max_length(16'd16);
    send_block_pair(16, 1'b0, FILL_RANDOM);
    send_faulty_data(TYPE_DATA, 17);
    send_faulty_data(32'h1234_5678, 17);

    phase_limits = '{16'hFFFF, 16'd0, 16'd1, 16'd24, 16'd300, MAX_LEN_RESET, 16'd0};
    phase_limits[6] = 16'($urandom_range(2, 512));
    for (int p = 0; p < 7; p++) begin
      set_max_length(phase_limits[p]);
      if (p == 1)
        press_output();
      mark = bytes_sent;
      while (bytes_sent - mark < RANDOM_BYTES_PER_PHASE)
        random_pair();
    end

    wait_idle();
    if (board.failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
